// File: rtl/gated_first_order_lag_sensor_assert.svh
// ----------------------------------------------------------------------------
// gated first-order lag sensor assertion macros
// shared property forms for the lag sensor modules, clocked on i_clk and
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef GATED_FIRST_ORDER_LAG_SENSOR_ASSERT_SVH
`define GATED_FIRST_ORDER_LAG_SENSOR_ASSERT_SVH

// same-cycle implication
`define GFOLS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GFOLS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gfols_pkg.sv
// ----------------------------------------------------------------------------
// gfols_pkg
// widths, transaction types and register indexes of the gated lag sensor
// ----------------------------------------------------------------------------
package gfols_pkg;

    localparam int VALUE_W    = 32;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 20;
    localparam int TCONST_W   = 24;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TCONST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd1000;
    localparam logic [TCONST_W-1:0] TCONST_RST = 24'd0;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd65536;

    // datapath widths
    localparam int D2_W   = TCONST_W + 1;          // 2 * time constant
    localparam int SMAG_W = VALUE_W + 1;           // |x + prev_x|
    localparam int T1_W   = TIME_W + VALUE_W;      // |2D - dt| * |y_prev|
    localparam int GS_W   = SMAG_W + GAIN_W;       // |g| * |x + prev_x|
    localparam int T2_W   = GS_W + TIME_W;         // dt * |g| * |x + prev_x|
    localparam int NUM_W  = T2_W + 2;              // signed numerator plus rounding
    localparam int DSUM_W = TIME_W + 1;            // 2D + dt
    localparam int DEN_W  = DSUM_W + GAIN_FRAC;
    localparam int QUO_W  = VALUE_W;

    typedef struct packed {
        logic [TIME_W-1:0]         time_us;
        logic signed [VALUE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] filtered;
        logic                      updated;
    } t_out_item;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

// File: rtl/gfols_mul.sv
// ----------------------------------------------------------------------------
// gfols_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`include "gated_first_order_lag_sensor_assert.svh"

module gfols_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic            o_done,
    output logic [AW+BW-1:0] o_prod
);
    localparam int CNT_W = $clog2(BW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_a;
    logic [AW+BW-1:0] r_p;

    logic [AW:0]      sum;
    logic [AW+BW-1:0] n_p;

    // upper half collects the partial sum, lower half holds the remaining multiplier bits
    always_comb begin
        sum = {1'b0, r_p[AW+BW-1:BW]} + (r_p[0] ? {1'b0, r_a} : {(AW+1){1'b0}});
        n_p = {sum, r_p[BW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

    `GFOLS_ASSERT_IMP(a_mul_no_restart, i_start, !r_busy, "multiplier restarted while busy")

endmodule

// File: rtl/gfols_div.sv
// ----------------------------------------------------------------------------
// gfols_div
// restoring divider, one quotient bit per cycle, with quotient overflow flag
// ----------------------------------------------------------------------------
`include "gated_first_order_lag_sensor_assert.svh"

module gfols_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gfols_pkg::NUM_W-1:0]  i_num,
    input  logic [gfols_pkg::DEN_W-1:0]  i_den,
    output gfols_pkg::t_div_stat         o_stat,
    output logic [gfols_pkg::QUO_W-1:0]  o_quot
);
    import gfols_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam int HI_W  = NUM_W - QUO_W;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_q;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    // dividend bits leave the top of r_q while quotient bits enter at the bottom
    always_comb begin
        shifted = {r_rem, r_q[QUO_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
        ge      = !trial[DEN_W+1];
        n_rem   = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quotient does not fit when the upper dividend part reaches the divisor
            r_ovf <= i_num[NUM_W-1:QUO_W] >= HI_W'(i_den);
            r_rem <= i_num[QUO_W+DEN_W-1:QUO_W];
            r_q   <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[QUO_W-2:0], ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quot      = r_q;

    `GFOLS_ASSERT_IMP(a_div_no_restart, i_start, !r_busy, "divider restarted while busy")

endmodule

// File: rtl/gated_first_order_lag_sensor.sv
// ----------------------------------------------------------------------------
// gated_first_order_lag_sensor
// Sensor with a first-order lag of gain G and time constant D, Tustin form.
// Each transaction brings a timestamp and a Q16.16 sample and returns one
// result. Elapsed time accumulates until it reaches the update period; then
// y = ((2D - dt) * y_prev + dt * G * (x + x_prev)) / (2D + dt) is formed,
// rounded to nearest and saturated, otherwise the last output is held. One
// transaction is worked at a time. A held transaction passes from ST_ACC
// straight to ST_DONE and then into the output register. An update runs
// mostly in the bit-serial multipliers (a 24-step gain multiply followed by
// a 32-step multiply by dt, with the 32-step lag term in parallel), then in
// the 32-step serial divider. The next transaction is accepted once the result
// is in the output register.
// ----------------------------------------------------------------------------
`include "gated_first_order_lag_sensor_assert.svh"

module gated_first_order_lag_sensor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  gfols_pkg::t_in_item               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output gfols_pkg::t_out_item              o_out_data,
    input  logic                              i_cfg_we,
    input  logic [gfols_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gfols_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import gfols_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ACC   = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_MULGO = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_NEG   = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;
    localparam logic [3:0] ST_ABS   = 4'd7;
    localparam logic [3:0] ST_RND   = 4'd8;
    localparam logic [3:0] ST_DIVGO = 4'd9;
    localparam logic [3:0] ST_DIV   = 4'd10;
    localparam logic [3:0] ST_SAT   = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    // configuration and filter state
    logic [3:0]          r_state;
    logic [3:0]          n_state;
    logic [PERIOD_W-1:0] r_period;
    logic [TCONST_W-1:0] r_tconst;
    logic [GAIN_W-1:0]   r_gain;
    logic [TIME_W-1:0]   r_accum;
    logic [TIME_W-1:0]   r_last_time;
    logic                r_started;
    logic [VALUE_W-1:0]  r_prev_out;
    logic [VALUE_W-1:0]  r_prev_samp;
    logic                r_out_valid;

    // per-transaction datapath
    logic [TIME_W-1:0]   r_step;
    logic [VALUE_W-1:0]  r_x;
    logic                r_upd;
    logic [TIME_W-1:0]   r_dt;
    logic [SMAG_W-1:0]   r_s;
    logic [TIME_W:0]     r_kdiff;
    logic [DSUM_W-1:0]   r_dsum;
    logic                r_sign1;
    logic                r_sign2;
    logic [NUM_W-1:0]    r_t1;
    logic [NUM_W-1:0]    r_t2;
    logic [NUM_W-1:0]    r_num;
    logic                r_neg;
    t_out_item           r_out_data;

    logic                in_acc;
    logic                out_load;
    logic [TIME_W:0]     acc_sum;
    logic [TIME_W-1:0]   acc_sat;
    logic [PERIOD_W-1:0] period_eff;
    logic                acc_hit;
    logic [D2_W-1:0]     d2;
    logic [TIME_W:0]     kabs;
    logic [TIME_W-1:0]   kmag;
    logic [VALUE_W-1:0]  pmag;
    logic [SMAG_W-1:0]   smag;
    logic [GAIN_W-1:0]   gmag;
    logic [NUM_W-1:0]    t1_ext;
    logic [NUM_W-1:0]    t2_ext;
    logic [VALUE_W-1:0]  lim;
    logic [VALUE_W-1:0]  q_sat;
    logic [VALUE_W-1:0]  res;

    logic                mul_go;
    logic                kp_done;
    logic [T1_W-1:0]     kp_prod;
    logic                gs_done;
    logic [GS_W-1:0]     gs_prod;
    logic                dt_done;
    logic [T2_W-1:0]     dt_prod;
    logic                div_go;
    t_div_stat           div_stat;
    logic [QUO_W-1:0]    div_quot;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign mul_go   = (r_state == ST_MULGO);
    assign div_go   = (r_state == ST_DIVGO);

    always_comb begin
        acc_sum    = {1'b0, r_accum} + {1'b0, r_step};
        acc_sat    = acc_sum[TIME_W] ? {TIME_W{1'b1}} : acc_sum[TIME_W-1:0];
        period_eff = (r_period == '0) ? PERIOD_W'(1) : r_period;
        acc_hit    = acc_sat >= TIME_W'(period_eff);

        d2   = {r_tconst, 1'b0};
        kabs = r_kdiff[TIME_W] ? ((TIME_W+1)'(0) - r_kdiff) : r_kdiff;
        kmag = kabs[TIME_W-1:0];
        pmag = r_prev_out[VALUE_W-1] ? (VALUE_W'(0) - r_prev_out) : r_prev_out;
        smag = r_s[SMAG_W-1] ? (SMAG_W'(0) - r_s) : r_s;
        gmag = r_gain[GAIN_W-1] ? (GAIN_W'(0) - r_gain) : r_gain;

        t1_ext = NUM_W'({kp_prod, {GAIN_FRAC{1'b0}}});
        t2_ext = NUM_W'(dt_prod);

        lim   = r_neg ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        q_sat = (div_stat.ovf || (div_quot > lim)) ? lim : div_quot;
        res   = r_neg ? (VALUE_W'(0) - q_sat) : q_sat;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_ACC;
            ST_ACC:   n_state = acc_hit ? ST_PREP : ST_DONE;
            ST_PREP:  n_state = ST_MULGO;
            ST_MULGO: n_state = ST_MUL;
            ST_MUL:   if (dt_done) n_state = ST_NEG;
            ST_NEG:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_ABS;
            ST_ABS:   n_state = ST_RND;
            ST_RND:   n_state = ST_DIVGO;
            ST_DIVGO: n_state = ST_DIV;
            ST_DIV:   if (div_stat.done) n_state = ST_SAT;
            ST_SAT:   n_state = ST_DONE;
            ST_DONE:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= PERIOD_RST;
            r_tconst    <= TCONST_RST;
            r_gain      <= GAIN_RST;
            r_accum     <= '0;
            r_last_time <= '0;
            r_started   <= 1'b0;
            r_prev_out  <= '0;
            r_prev_samp <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PERIOD: r_period <= i_cfg_wdata[PERIOD_W-1:0];
                    CFG_TCONST: r_tconst <= i_cfg_wdata[TCONST_W-1:0];
                    CFG_GAIN:   r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_last_time <= i_in_data.time_us;
                // first transaction seeds both histories with its own sample
                if (!r_started) begin
                    r_started   <= 1'b1;
                    r_prev_out  <= i_in_data.sample;
                    r_prev_samp <= i_in_data.sample;
                end
            end
            if (r_state == ST_ACC) begin
                r_accum <= acc_hit ? '0 : acc_sat;
            end
            if (r_state == ST_SAT) begin
                r_prev_out  <= res;
                r_prev_samp <= r_x;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_step <= i_in_data.time_us - r_last_time;
            r_x    <= i_in_data.sample;
        end
        if (r_state == ST_ACC) begin
            r_upd <= acc_hit;
            r_dt  <= acc_sat;
            r_s   <= {r_x[VALUE_W-1], r_x} + {r_prev_samp[VALUE_W-1], r_prev_samp};
        end
        if (r_state == ST_PREP) begin
            r_kdiff <= (TIME_W+1)'(d2) - {1'b0, r_dt};
            r_dsum  <= DSUM_W'(d2) + {1'b0, r_dt};
        end
        if (r_state == ST_MULGO) begin
            r_sign1 <= r_kdiff[TIME_W] ^ r_prev_out[VALUE_W-1];
            r_sign2 <= r_gain[GAIN_W-1] ^ r_s[SMAG_W-1];
        end
        if (r_state == ST_NEG) begin
            r_t1 <= r_sign1 ? (NUM_W'(0) - t1_ext) : t1_ext;
            r_t2 <= r_sign2 ? (NUM_W'(0) - t2_ext) : t2_ext;
        end
        if (r_state == ST_SUM) begin
            r_num <= r_t1 + r_t2;
        end
        if (r_state == ST_ABS) begin
            r_neg <= r_num[NUM_W-1];
            r_num <= r_num[NUM_W-1] ? (NUM_W'(0) - r_num) : r_num;
        end
        if (r_state == ST_RND) begin
            // half the divisor, for round to nearest
            r_num <= r_num + NUM_W'({r_dsum, {(GAIN_FRAC-1){1'b0}}});
        end
        if (out_load) begin
            r_out_data.filtered <= r_prev_out;
            r_out_data.updated  <= r_upd;
        end
    end

    gfols_mul #(
        .AW (TIME_W),
        .BW (VALUE_W)
    ) u_mul_kp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (kmag),
        .i_b     (pmag),
        .o_done  (kp_done),
        .o_prod  (kp_prod)
    );

    gfols_mul #(
        .AW (SMAG_W),
        .BW (GAIN_W)
    ) u_mul_gs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_go),
        .i_a     (smag),
        .i_b     (gmag),
        .o_done  (gs_done),
        .o_prod  (gs_prod)
    );

    // gain times sample sum goes on to the dt multiply as soon as it is ready
    gfols_mul #(
        .AW (GS_W),
        .BW (TIME_W)
    ) u_mul_dt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gs_done),
        .i_a     (gs_prod),
        .i_b     (r_dt),
        .o_done  (dt_done),
        .o_prod  (dt_prod)
    );

    gfols_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (r_num),
        .i_den   ({r_dsum, {GAIN_FRAC{1'b0}}}),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `GFOLS_ASSERT_IMP(a_lag_term_first, dt_done, !kp_done, "lag term multiply finished late")
    `GFOLS_ASSERT_IMP(a_div_in_div, div_stat.done, r_state == ST_DIV, "divider done outside wait")
    `GFOLS_ASSERT_IMP(a_den_nonzero, div_go, r_dsum != '0, "divider started with zero divisor")
    `GFOLS_ASSERT_NXT(a_held_keeps_out, (r_state == ST_ACC) && !acc_hit,
                      $stable(r_prev_out), "held transaction changed the output")

endmodule

// File: verif/lag_sensor_checker.sv
// ----------------------------------------------------------------------------
// lag_sensor_checker
// Watches the input, output and register ports of the gated lag sensor.
// Keeps its own copy of the registers and filter state, works out the
// result of every accepted transaction and compares each returned result
// in order against it.
// ----------------------------------------------------------------------------
module lag_sensor_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  gfols_pkg::t_in_item              i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  gfols_pkg::t_out_item             i_out_data,
    input  logic                             i_cfg_we,
    input  logic [gfols_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gfols_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                               o_mismatches,
    output int                               o_pending,
    output int                               o_items,
    output int                               o_updates
);
    import gfols_pkg::*;

    logic [PERIOD_W-1:0]       period_us;
    logic [TCONST_W-1:0]       tconst_us;
    logic signed [GAIN_W-1:0]  gain_q16;

    logic [TIME_W-1:0]         accum_us;
    logic [TIME_W-1:0]         last_time_us;
    logic                      seeded;
    logic signed [VALUE_W-1:0] held_output;
    logic signed [VALUE_W-1:0] held_sample;

    t_out_item filtered_due[$];
    int mismatches = 0;
    int items      = 0;
    int updates    = 0;

    // tustin step: ((2D - dt) * y + dt * G * (x + x_prev)) / (2D + dt),
    // rounded half away from zero and clamped to the output range
    function automatic logic signed [VALUE_W-1:0] tustin_output(
        input logic [TIME_W-1:0]         dt,
        input logic signed [VALUE_W-1:0] x
    );
        logic signed [127:0] k;
        logic signed [127:0] p;
        logic signed [127:0] g;
        logic signed [127:0] s;
        logic signed [127:0] dtw;
        logic signed [127:0] num;
        logic [127:0]        mag;
        logic [127:0]        den;
        logic [127:0]        q;
        logic [127:0]        lim;
        k   = $signed({103'd0, tconst_us, 1'b0}) - $signed({96'd0, dt});
        p   = 128'(held_output);
        g   = 128'(gain_q16);
        s   = 128'(x) + 128'(held_sample);
        dtw = $signed({96'd0, dt});
        num = ((k * p) <<< GAIN_FRAC) + dtw * g * s;
        mag = num[127] ? -num : num;
        den = ({103'd0, tconst_us, 1'b0} + {96'd0, dt}) << GAIN_FRAC;
        q   = (mag + (den >> 1)) / den;
        lim = num[127] ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            q = lim;
        end
        return num[127] ? -q[VALUE_W-1:0] : q[VALUE_W-1:0];
    endfunction

    function automatic t_out_item advance_sensor(input t_in_item item);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] dt;
        logic              upd;
        t_out_item         res;
        step     = item.time_us - last_time_us;
        sum      = {1'b0, accum_us} + {1'b0, step};
        accum_us = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        period   = TIME_W'(period_us);
        if (period_us == '0) begin
            period = 1;
        end
        upd = (accum_us >= period);
        dt  = accum_us;
        if (upd) begin
            accum_us = '0;
        end
        // first transaction seeds both history values with its own sample
        if (!seeded) begin
            held_output = item.sample;
            held_sample = item.sample;
            seeded      = 1'b1;
        end
        if (upd) begin
            held_output = tustin_output(dt, item.sample);
            held_sample = item.sample;
        end
        last_time_us = item.time_us;
        res.filtered = held_output;
        res.updated  = upd;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            period_us    = PERIOD_RST;
            tconst_us    = TCONST_RST;
            gain_q16     = GAIN_RST;
            accum_us     = '0;
            last_time_us = '0;
            seeded       = 1'b0;
            held_output  = '0;
            held_sample  = '0;
            filtered_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PERIOD: period_us = i_cfg_wdata[PERIOD_W-1:0];
                    CFG_TCONST: tconst_us = i_cfg_wdata[TCONST_W-1:0];
                    CFG_GAIN:   gain_q16  = i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                want = advance_sensor(i_in_data);
                filtered_due.push_back(want);
                items++;
                if (want.updated) begin
                    updates++;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (filtered_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: filtered %0d updated %0b",
                                 i_out_data.filtered, i_out_data.updated);
                    end
                end else begin
                    want = filtered_due.pop_front();
                    if (i_out_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: filtered %0d want %0d, updated %0b want %0b",
                                     i_out_data.filtered, want.filtered,
                                     i_out_data.updated, want.updated);
                        end
                    end
                end
            end
        end
        o_pending    <= filtered_due.size();
        o_mismatches <= mismatches;
        o_items      <= items;
        o_updates    <= updates;
    end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for the gated first-order lag sensor. A directed sequence hits
// sample extremes, time wrap, accumulator saturation, zero period and output
// saturation; random phases then run under several register settings with
// bursty input traffic and output backpressure. Checking is done by
// lag_sensor_checker.
// ----------------------------------------------------------------------------
module testbench;
    import gfols_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 78;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    int mismatches;
    int pending;
    int items;
    int updates;

    int unsigned cur_period = 32'(PERIOD_RST);
    logic [TIME_W-1:0] stamp_us = '0;
    int  burst_left = 0;
    bit  no_gaps    = 1'b0;
    int  settings   = 1;
    int  quiet      = 0;
    int  seg_left   = 0;
    int  stall_mode = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    gated_first_order_lag_sensor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    lag_sensor_checker lag_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_items      (items),
        .o_updates    (updates)
    );

    // receiver backpressure: segments of free flow, coin flips and long stalls
    always @(negedge clk) begin
        if (seg_left == 0) begin
            seg_left   <= $urandom_range(20, 200);
            stall_mode <= $urandom_range(0, 2);
            out_stall  <= 1'b0;
        end else begin
            seg_left <= seg_left - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= (seg_left % 40) < 25;
            endcase
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("gated_first_order_lag_sensor regression: fail");
            $finish;
        end
    end

    task automatic send_sample(input logic [TIME_W-1:0] stamp,
                               input logic signed [VALUE_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= '{time_us: stamp, sample: value};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps) begin
                gap = $urandom_range(1, 8);
                repeat (gap) begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
            end
        end
        burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_PERIOD) begin
            cur_period = 32'(value[PERIOD_W-1:0]);
        end
    endtask

    task automatic set_regs(input logic [PERIOD_W-1:0] period,
                            input logic [TCONST_W-1:0] tconst,
                            input logic [GAIN_W-1:0]   gain);
        drain();
        write_reg(CFG_PERIOD, CFG_DATA_W'(period));
        write_reg(CFG_TCONST, CFG_DATA_W'(tconst));
        write_reg(CFG_GAIN,   CFG_DATA_W'(gain));
        settings++;
    endtask

    task automatic directed_part();
        // seed, held transactions and extremes under reset settings
        send_sample(32'd0,    32'sh7FFF_FFFF);
        send_sample(32'd400,  32'sh8000_0000);
        send_sample(32'd1000, 32'sh7FFF_FFFF);
        send_sample(32'd2000, 32'sh8000_0000);
        send_sample(32'd3000, 32'sh8000_0000);
        send_sample(32'd3000, 32'sh0000_0000);
        // timestamp wraps around
        send_sample(32'hFFFF_FF00, 32'sh0001_0000);
        send_sample(32'h0000_0100, -32'sd1);
        send_sample(32'h0000_0300, 32'sh0000_8000);
        // a backward step saturates the accumulator
        send_sample(32'h0000_0400, 32'sd5);
        send_sample(32'h0000_03FF, -32'sd5);
        // zero period acts as one, big gain drives the output into clamp
        set_regs(20'd0, 24'd0, 24'h7FFFFF);
        send_sample(32'h0000_03FF, 32'sh4000_0000);
        send_sample(32'h0000_0400, 32'sh4000_0000);
        send_sample(32'h0000_0401, 32'sh8000_0000);
        set_regs(20'd0, 24'd0, 24'h800000);
        send_sample(32'h0000_0402, 32'sh7FFF_FFFF);
        send_sample(32'h0000_0403, 32'sh0001_0000);
        // longest period and time constant
        set_regs(20'hFFFFF, 24'hFFFFFF, 24'h010000);
        send_sample(32'h0000_0404, 32'sh0001_0000);
        send_sample(32'h0000_0404 + 32'h000F_FFFF, -32'sh0001_0000);
        stamp_us = 32'h0000_0404 + 32'h000F_FFFF;
    endtask

    task automatic random_phase(input int count);
        logic [TIME_W-1:0]         step;
        logic signed [VALUE_W-1:0] value;
        int unsigned               per;
        no_gaps    = ($urandom_range(0, 3) == 0);
        burst_left = 0;
        per        = (cur_period == 0) ? 1 : cur_period;
        repeat (count) begin
            pace();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: step = $urandom_range(0, per / 3 + 1);
                5, 6:          step = per + $urandom_range(0, per / 2);
                7:             step = '0;
                8:             step = $urandom;
                default:       step = per;
            endcase
            case ($urandom_range(0, 7))
                0: begin
                    case ($urandom_range(0, 3))
                        0:       value = 32'sh7FFF_FFFF;
                        1:       value = 32'sh8000_0000;
                        2:       value = '0;
                        default: value = -32'sd1;
                    endcase
                end
                1, 2:    value = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                default: value = $urandom;
            endcase
            stamp_us = stamp_us + step;
            send_sample(stamp_us, value);
        end
    endtask

    initial begin
        logic [PERIOD_W-1:0] period;
        logic [TCONST_W-1:0] tconst;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_part();

        set_regs(20'd1, 24'd0, 24'h010000);
        random_phase(PHASE_ITEMS);
        set_regs(20'hFFFFF, 24'hFFFFFF, 24'h7FFFFF);
        random_phase(PHASE_ITEMS);
        set_regs(20'd0, 24'd16, 24'h800000);
        random_phase(PHASE_ITEMS);
        repeat (5) begin
            if ($urandom_range(0, 3) == 0) begin
                period = PERIOD_W'($urandom_range(0, 20'hFFFFF));
            end else begin
                period = PERIOD_W'($urandom_range(1, 5000));
            end
            case ($urandom_range(0, 2))
                0:       tconst = '0;
                1:       tconst = TCONST_W'($urandom_range(0, 2000));
                default: tconst = TCONST_W'($urandom);
            endcase
            set_regs(period, tconst, GAIN_W'($urandom));
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d transactions with %0d filter updates over %0d register settings",
                 items, updates, settings);
        if (mismatches == 0 && pending == 0) begin
            $display("gated_first_order_lag_sensor regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("gated_first_order_lag_sensor regression: fail");
        end
        $finish;
    end

endmodule
